[src/mcpi_pkg.sv]
// Shared types and constants for the motor current PI controller.
package mcpi_pkg;

  // Operating modes
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FIXED = 2'd1,
    MODE_TUNE  = 2'd2,
    MODE_TRACK = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 2'd0,
    CFG_DUTY = 2'd1,
    CFG_KP   = 2'd2,
    CFG_KI   = 2'd3
  } cfg_idx_t;

  // Field widths
  localparam int CUR_W  = 13;
  localparam int ERR_W  = CUR_W + 1;
  localparam int DUTY_W = 8;
  localparam int GAIN_W = 16;
  localparam int INT_W  = 32;
  localparam int CMP_W  = 12;
  localparam int MAG_W  = 7;
  localparam int PKP_W  = GAIN_W + ERR_W;
  localparam int PKI_W  = GAIN_W + INT_W;
  localparam int SUM_W  = PKI_W + 1;
  localparam int QSH    = 8;

  // Limits
  localparam int PCT_FULL = 100;
  localparam logic signed [DUTY_W-1:0] DUTY_HI = 8'sd100;
  localparam logic signed [DUTY_W-1:0] DUTY_LO = -8'sd100;
  localparam logic [CMP_W-1:0] CMP_MAX = 12'd4095;

  // Square-wave levels in tune mode, mA
  localparam logic signed [CUR_W-1:0] TUNE_HI = 13'sd200;
  localparam logic signed [CUR_W-1:0] TUNE_LO = -13'sd200;

  // Configuration registers
  typedef struct packed {
    mode_t                     mode;
    logic signed [DUTY_W-1:0]  duty_cycle;
    logic signed [GAIN_W-1:0]  kp_gain;
    logic signed [GAIN_W-1:0]  ki_gain;
  } cfg_t;

  // Stage between the PI products and the drive output
  typedef struct packed {
    logic                      upd;
    logic                      use_pi;
    logic                      log_vld;
    logic signed [DUTY_W-1:0]  duty;
    logic signed [CUR_W-1:0]   log_ref;
    logic signed [CUR_W-1:0]   log_sens;
    logic signed [PKP_W-1:0]   p_kp;
    logic signed [PKI_W-1:0]   p_ki;
  } law_t;

endpackage

[src/mcpi_cfg.sv]
// Configuration register file of the motor current PI controller.
module mcpi_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mcpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcpi_pkg::CFG_DATA_W-1:0]   cfg_data,
  output mcpi_pkg::cfg_t                    cfg,
  output logic                              cfg_clr
);
  import mcpi_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode a write; every listed register write also clears the integral
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE: cfg_nxt.mode       = mode_t'(cfg_data[1:0]);
        CFG_DUTY: cfg_nxt.duty_cycle = cfg_data[DUTY_W-1:0];
        CFG_KP:   cfg_nxt.kp_gain    = cfg_data[GAIN_W-1:0];
        CFG_KI:   cfg_nxt.ki_gain    = cfg_data[GAIN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mode: MODE_IDLE, duty_cycle: '0, kp_gain: '0, ki_gain: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg     = cfg_r;
  assign cfg_clr = cfg_we;

endmodule

[src/mcpi_law.sv]
// Input register, integral and square-wave state, and PI gain products.
module mcpi_law #(
  parameter int HALF_WAVE_TICKS = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mcpi_pkg::cfg_t                     cfg,
  input  logic                               cfg_clr,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [mcpi_pkg::CUR_W-1:0]  in_sensed_current,
  input  logic signed [mcpi_pkg::CUR_W-1:0]  in_reference_current,
  input  logic                               in_storing_data,
  input  logic                               in_clear_integral,
  input  logic                               drv_take,
  output logic                               law_valid,
  output mcpi_pkg::law_t                     law
);
  import mcpi_pkg::*;

  localparam int PH_W = (2 * HALF_WAVE_TICKS > 2) ? $clog2(2 * HALF_WAVE_TICKS) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(2 * HALF_WAVE_TICKS - 1);
  localparam logic [PH_W-1:0] PH_HALF = PH_W'(HALF_WAVE_TICKS);

  // Input request register
  logic                     s0_v_r;
  logic signed [CUR_W-1:0]  sens_r;
  logic signed [CUR_W-1:0]  ref_r;
  logic                     store_r;
  logic                     clr_r;

  // Controller state
  logic signed [INT_W-1:0]  integral_r;
  logic signed [INT_W-1:0]  integral_nxt;
  logic [PH_W-1:0]          phase_r;
  logic [PH_W-1:0]          phase_nxt;

  // Product stage
  logic   s1_v_r;
  law_t   s1_r;
  law_t   s1_nxt;

  logic                     s1_free;
  logic                     s0_move;
  logic signed [INT_W-1:0]  base;
  logic [PH_W-1:0]          phase_inc;
  logic signed [CUR_W-1:0]  pi_ref;
  logic signed [ERR_W-1:0]  err;
  logic [INT_W:0]           acc_wide;
  logic signed [INT_W-1:0]  acc;
  logic                     run_pi;
  logic                     tune_on;
  logic signed [DUTY_W-1:0] duty_sat;

  // Handshake
  assign s1_free  = !s1_v_r || drv_take;
  assign s0_move  = s0_v_r && s1_free;
  assign in_ready = !s0_v_r || s1_free;

  // Integral base, square-wave phase and error
  assign base      = clr_r ? '0 : integral_r;
  assign phase_inc = (phase_r == PH_LAST) ? '0 : phase_r + 1'b1;
  assign tune_on   = (cfg.mode == MODE_TUNE) && store_r;
  assign run_pi    = (cfg.mode == MODE_TRACK) || tune_on;
  assign pi_ref    = (cfg.mode == MODE_TUNE) ?
                     ((phase_inc < PH_HALF) ? TUNE_HI : TUNE_LO) : ref_r;
  assign err       = {pi_ref[CUR_W-1], pi_ref} - {sens_r[CUR_W-1], sens_r};

  // Saturating integral update
  assign acc_wide = {base[INT_W-1], base} + {{(INT_W+1-ERR_W){err[ERR_W-1]}}, err};
  always_comb begin
    if (acc_wide[INT_W] != acc_wide[INT_W-1]) begin
      acc = acc_wide[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end else begin
      acc = acc_wide[INT_W-1:0];
    end
  end

  // Fixed duty limited to full scale
  always_comb begin
    if (cfg.duty_cycle > DUTY_HI) begin
      duty_sat = DUTY_HI;
    end else if (cfg.duty_cycle < DUTY_LO) begin
      duty_sat = DUTY_LO;
    end else begin
      duty_sat = cfg.duty_cycle;
    end
  end

  // Per-mode control word and gain products
  always_comb begin
    s1_nxt          = '0;
    s1_nxt.p_kp     = cfg.kp_gain * err;
    s1_nxt.p_ki     = cfg.ki_gain * acc;
    s1_nxt.log_ref  = pi_ref;
    s1_nxt.log_sens = sens_r;
    unique case (cfg.mode)
      MODE_IDLE: begin
        s1_nxt.upd  = 1'b1;
      end
      MODE_FIXED: begin
        s1_nxt.upd  = 1'b1;
        s1_nxt.duty = duty_sat;
      end
      MODE_TUNE: begin
        s1_nxt.upd     = store_r;
        s1_nxt.use_pi  = store_r;
        s1_nxt.log_vld = store_r;
      end
      MODE_TRACK: begin
        s1_nxt.upd    = 1'b1;
        s1_nxt.use_pi = 1'b1;
      end
    endcase
  end

  // State advance when a request leaves the input register
  assign integral_nxt = run_pi ? acc : base;
  assign phase_nxt    = tune_on ? phase_inc : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r     <= 1'b0;
      s1_v_r     <= 1'b0;
      integral_r <= '0;
      phase_r    <= PH_LAST;
    end else begin
      if (in_ready) begin
        s0_v_r <= in_valid;
      end
      if (s1_free) begin
        s1_v_r <= s0_v_r;
      end
      if (cfg_clr) begin
        integral_r <= '0;
      end else if (s0_move) begin
        integral_r <= integral_nxt;
      end
      if (s0_move) begin
        phase_r <= phase_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sens_r  <= in_sensed_current;
      ref_r   <= in_reference_current;
      store_r <= in_storing_data;
      clr_r   <= in_clear_integral;
    end
    if (s0_move) begin
      s1_r <= s1_nxt;
    end
  end

  assign law_valid = s1_v_r;
  assign law       = s1_r;

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_LAST)
    else $error("square-wave phase out of range");

  a_integral_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!s0_move && !cfg_clr) |=> $stable(integral_r))
    else $error("integral changed without a request");

  a_phase_only_tune: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_move && !tune_on) |=> $stable(phase_r))
    else $error("phase advanced outside tune storing");
`endif

endmodule

[src/mcpi_drive.sv]
// Scale and limit the PI sum, map duty to PWM compare, hold the result.
module mcpi_drive #(
  parameter int PWM_PERIOD = 4000
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 law_valid,
  input  mcpi_pkg::law_t                       law,
  output logic                                 drv_take,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_pwm_update,
  output logic [mcpi_pkg::CMP_W-1:0]           out_pwm_compare,
  output logic                                 out_direction,
  output logic                                 out_log_valid,
  output logic signed [mcpi_pkg::CUR_W-1:0]    out_log_reference,
  output logic signed [mcpi_pkg::CUR_W-1:0]    out_log_sensor,
  output logic signed [mcpi_pkg::DUTY_W-1:0]   out_log_control
);
  import mcpi_pkg::*;

  localparam int TAB_N = 2 ** MAG_W;

  logic [CMP_W-1:0] cmp_tab [TAB_N];

  // Compare per duty magnitude, worked out at elaboration
  for (genvar g = 0; g < TAB_N; g++) begin : g_cmp
    localparam int Pct = (g > PCT_FULL) ? PCT_FULL : g;
    localparam int Raw = (Pct * PWM_PERIOD) / PCT_FULL;
    assign cmp_tab[g] = (Raw > int'(CMP_MAX)) ? CMP_MAX : CMP_W'(Raw);
  end

  logic                      out_valid_r;
  logic                      upd_r;
  logic [CMP_W-1:0]          cmp_r;
  logic                      dir_r;
  logic                      log_vld_r;
  logic signed [CUR_W-1:0]   log_ref_r;
  logic signed [CUR_W-1:0]   log_sens_r;
  logic signed [DUTY_W-1:0]  log_ctl_r;

  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-QSH-1:0]   quo;
  logic signed [DUTY_W-1:0]      u_pi;
  logic signed [DUTY_W-1:0]      u;
  logic [DUTY_W-1:0]             u_abs;
  logic [MAG_W-1:0]              mag;

  assign drv_take = !out_valid_r || out_ready;

  // PI sum divided by 256, truncated toward zero
  assign sum = {{(SUM_W-PKP_W){law.p_kp[PKP_W-1]}}, law.p_kp} +
               {{(SUM_W-PKI_W){law.p_ki[PKI_W-1]}}, law.p_ki};
  assign quo = sum[SUM_W-1:QSH] +
               {{(SUM_W-QSH-1){1'b0}}, (sum[SUM_W-1] && (|sum[QSH-1:0]))};

  // Clamp to full scale
  always_comb begin
    if (quo > (SUM_W-QSH)'(PCT_FULL)) begin
      u_pi = DUTY_HI;
    end else if (quo < -(SUM_W-QSH)'(PCT_FULL)) begin
      u_pi = DUTY_LO;
    end else begin
      u_pi = quo[DUTY_W-1:0];
    end
  end

  assign u     = law.use_pi ? u_pi : law.duty;
  assign u_abs = u[DUTY_W-1] ? -u : u;
  assign mag   = u_abs[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (drv_take) begin
      out_valid_r <= law_valid;
    end
  end

  // Result register; unused fields read as zero
  always_ff @(posedge clk) begin
    if (law_valid && drv_take) begin
      upd_r      <= law.upd;
      cmp_r      <= law.upd ? cmp_tab[mag] : '0;
      dir_r      <= law.upd && !u[DUTY_W-1];
      log_vld_r  <= law.log_vld;
      log_ref_r  <= law.log_vld ? law.log_ref : '0;
      log_sens_r <= law.log_vld ? law.log_sens : '0;
      log_ctl_r  <= law.log_vld ? u : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pwm_update    = upd_r;
  assign out_pwm_compare   = cmp_r;
  assign out_direction     = dir_r;
  assign out_log_valid     = log_vld_r;
  assign out_log_reference = log_ref_r;
  assign out_log_sensor    = log_sens_r;
  assign out_log_control   = log_ctl_r;

`ifndef SYNTHESIS
  a_no_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !upd_r) |-> (cmp_r == '0 && !dir_r && !log_vld_r))
    else $error("idle result carries drive data");

  a_log_implies_update: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && log_vld_r) |-> upd_r)
    else $error("log record without PWM update");
`endif

endmodule

[src/motor_current_pi_controller_unit.sv]
// Top level of the motor current PI controller.
//
//   channel | ports                          | moves
//   --------+--------------------------------+---------------------------------
//   input   | in_valid / in_ready            | one control tick request
//   result  | out_valid / out_ready          | PWM compare, direction, log data
//   config  | cfg_we, cfg_index, cfg_data    | register write, no wait
//
// A request passes the input register, which loads at acceptance, then the PI
// product and result registers. One request is accepted every cycle unless the
// output stalls; the saturating integral adder is the widest single-cycle loop,
// and the gain products follow it in the same cycle. Synchronous active-low
// reset clears valids and integral and sets the square phase to its last step.
// A stalled output holds the pipeline back stage by stage; no request is lost.
module motor_current_pi_controller_unit #(
  parameter int PWM_PERIOD      = 4000,
  parameter int HALF_WAVE_TICKS = 25
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mcpi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mcpi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mcpi_pkg::CUR_W-1:0]    in_sensed_current,
  input  logic signed [mcpi_pkg::CUR_W-1:0]    in_reference_current,
  input  logic                                 in_storing_data,
  input  logic                                 in_clear_integral,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_pwm_update,
  output logic [mcpi_pkg::CMP_W-1:0]           out_pwm_compare,
  output logic                                 out_direction,
  output logic                                 out_log_valid,
  output logic signed [mcpi_pkg::CUR_W-1:0]    out_log_reference,
  output logic signed [mcpi_pkg::CUR_W-1:0]    out_log_sensor,
  output logic signed [mcpi_pkg::DUTY_W-1:0]   out_log_control
);
  import mcpi_pkg::*;

  cfg_t  cfg;
  logic  cfg_clr;
  logic  drv_take;
  logic  law_valid;
  law_t  law;

  mcpi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_clr   (cfg_clr)
  );

  mcpi_law #(
    .HALF_WAVE_TICKS (HALF_WAVE_TICKS)
  ) u_law (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .cfg_clr              (cfg_clr),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sensed_current    (in_sensed_current),
    .in_reference_current (in_reference_current),
    .in_storing_data      (in_storing_data),
    .in_clear_integral    (in_clear_integral),
    .drv_take             (drv_take),
    .law_valid            (law_valid),
    .law                  (law)
  );

  mcpi_drive #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_drive (
    .clk               (clk),
    .rst_n             (rst_n),
    .law_valid         (law_valid),
    .law               (law),
    .drv_take          (drv_take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pwm_update    (out_pwm_update),
    .out_pwm_compare   (out_pwm_compare),
    .out_direction     (out_direction),
    .out_log_valid     (out_log_valid),
    .out_log_reference (out_log_reference),
    .out_log_sensor    (out_log_sensor),
    .out_log_control   (out_log_control)
  );

endmodule

[dv/pi_tick_checker.sv]
// Checker for the motor current PI controller: predicts each drive result and compares it.
module pi_tick_checker #(
  parameter int PWM_PERIOD      = 4000,
  parameter int HALF_WAVE_TICKS = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mcpi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcpi_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [mcpi_pkg::CUR_W-1:0]   in_sensed_current,
  input  logic signed [mcpi_pkg::CUR_W-1:0]   in_reference_current,
  input  logic                                in_storing_data,
  input  logic                                in_clear_integral,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_pwm_update,
  input  logic [mcpi_pkg::CMP_W-1:0]          out_pwm_compare,
  input  logic                                out_direction,
  input  logic                                out_log_valid,
  input  logic signed [mcpi_pkg::CUR_W-1:0]   out_log_reference,
  input  logic signed [mcpi_pkg::CUR_W-1:0]   out_log_sensor,
  input  logic signed [mcpi_pkg::DUTY_W-1:0]  out_log_control,
  output int                                  fail_count,
  output int                                  pending_results,
  output int                                  results_checked
);
  import mcpi_pkg::*;

  localparam longint SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SUM_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic                     pwm_update;
    logic [CMP_W-1:0]         pwm_compare;
    logic                     direction;
    logic                     log_valid;
    logic signed [CUR_W-1:0]  log_reference;
    logic signed [CUR_W-1:0]  log_sensor;
    logic signed [DUTY_W-1:0] log_control;
  } drive_result_t;

  drive_result_t            pending_drives[$];
  drive_result_t            want;

  // Shadow copy of the registers and the controller state
  mode_t                    mode_q;
  logic signed [DUTY_W-1:0] duty_q;
  logic signed [GAIN_W-1:0] kp_q;
  logic signed [GAIN_W-1:0] ki_q;
  logic signed [INT_W-1:0]  integral_q;
  int unsigned              square_pos;

  // PI law: integral advances by the error and saturates, sum truncates toward zero
  function automatic int pi_effort(int target, int sensed);
    longint err;
    longint acc;
    longint u;
    err = target - sensed;
    acc = longint'(integral_q) + err;
    if (acc > SUM_MAX) acc = SUM_MAX;
    if (acc < SUM_MIN) acc = SUM_MIN;
    integral_q = INT_W'(acc);
    u = (longint'(kp_q) * err + longint'(ki_q) * acc) / 256;
    if (u > PCT_FULL) u = PCT_FULL;
    if (u < -PCT_FULL) u = -PCT_FULL;
    return int'(u);
  endfunction

  // Duty in percent to compare value and direction
  function automatic drive_result_t duty_drive(int duty);
    drive_result_t r;
    longint mag;
    r = '0;
    if (duty > PCT_FULL) duty = PCT_FULL;
    if (duty < -PCT_FULL) duty = -PCT_FULL;
    mag = (duty < 0) ? -duty : duty;
    mag = mag * PWM_PERIOD / PCT_FULL;
    if (mag > CMP_MAX) mag = CMP_MAX;
    r.pwm_update  = 1'b1;
    r.pwm_compare = CMP_W'(mag);
    r.direction   = (duty >= 0);
    return r;
  endfunction

  function automatic drive_result_t predict_drive(int sensed, int target,
                                                  logic storing, logic clear);
    drive_result_t r;
    int tune_ref;
    int effort;
    r = '0;
    if (clear) integral_q = '0;
    case (mode_q)
      MODE_IDLE:  r = duty_drive(0);
      MODE_FIXED: r = duty_drive(duty_q);
      MODE_TUNE: begin
        // square reference steps only while data are stored; otherwise all zero
        if (storing) begin
          square_pos++;
          if (square_pos >= 2 * HALF_WAVE_TICKS) square_pos = 0;
          tune_ref = (square_pos < HALF_WAVE_TICKS) ? int'(TUNE_HI) : int'(TUNE_LO);
          effort = pi_effort(tune_ref, sensed);
          r = duty_drive(effort);
          r.log_valid     = 1'b1;
          r.log_reference = CUR_W'(tune_ref);
          r.log_sensor    = CUR_W'(sensed);
          r.log_control   = DUTY_W'(effort);
        end
      end
      default: r = duty_drive(pi_effort(target, sensed));
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want_v,
                                      logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q     = MODE_IDLE;
      duty_q     = '0;
      kp_q       = '0;
      ki_q       = '0;
      integral_q = '0;
      square_pos = 2 * HALF_WAVE_TICKS - 1;
      pending_drives.delete();
      fail_count      = 0;
      results_checked = 0;
    end else begin
      // results first: a result can never match a request taken on the same edge
      if (out_valid && out_ready) begin
        if (pending_drives.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = pending_drives.pop_front();
          check_field("pwm_update", want.pwm_update, out_pwm_update);
          check_field("pwm_compare", want.pwm_compare, out_pwm_compare);
          check_field("direction", want.direction, out_direction);
          check_field("log_valid", want.log_valid, out_log_valid);
          check_field("log_reference", $signed(want.log_reference), out_log_reference);
          check_field("log_sensor", $signed(want.log_sensor), out_log_sensor);
          check_field("log_control", $signed(want.log_control), out_log_control);
          results_checked++;
        end
      end
      // any register write also clears the integral
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MODE: mode_q = mode_t'(cfg_data[1:0]);
          CFG_DUTY: duty_q = cfg_data[DUTY_W-1:0];
          CFG_KP:   kp_q = cfg_data;
          CFG_KI:   ki_q = cfg_data;
          default: ;
        endcase
        integral_q = '0;
      end
      if (in_valid && in_ready)
        pending_drives.push_back(predict_drive(in_sensed_current, in_reference_current,
                                               in_storing_data, in_clear_integral));
    end
    pending_results = pending_drives.size();
  end

endmodule

[dv/motor_current_pi_controller_unit_tb.sv]
// Testbench top for the motor current PI controller: stimulus, flow control and verdict.
module motor_current_pi_controller_unit_tb;
  import mcpi_pkg::*;

  localparam int     PWM_PERIOD      = 4000;
  localparam int     HALF_WAVE_TICKS = 25;
  localparam int     CLK_HALF        = 6;
  localparam longint TIMEOUT_UNITS   = 48_000_000;
  localparam int     RAND_PHASES     = 16;
  localparam int     PHASE_TICKS     = 100;
  localparam int     SAT_TICKS       = 24;          // full-scale error, back to back
  localparam logic signed [CUR_W-1:0] CUR_MAX = 13'sh0FFF;
  localparam logic signed [CUR_W-1:0] CUR_MIN = 13'sh1000;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [CUR_W-1:0]   in_sensed_current;
  logic signed [CUR_W-1:0]   in_reference_current;
  logic                      in_storing_data;
  logic                      in_clear_integral;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_pwm_update;
  logic [CMP_W-1:0]          out_pwm_compare;
  logic                      out_direction;
  logic                      out_log_valid;
  logic signed [CUR_W-1:0]   out_log_reference;
  logic signed [CUR_W-1:0]   out_log_sensor;
  logic signed [DUTY_W-1:0]  out_log_control;
  int                        fail_count;
  int                        pending_results;
  int                        results_checked;

  logic rx_free;     // receiver always ready while set
  int   burst_left;
  int   n_items;
  int   n_settings;

  motor_current_pi_controller_unit #(
    .PWM_PERIOD(PWM_PERIOD),
    .HALF_WAVE_TICKS(HALF_WAVE_TICKS)
  ) dut (.*);

  pi_tick_checker #(
    .PWM_PERIOD(PWM_PERIOD),
    .HALF_WAVE_TICKS(HALF_WAVE_TICKS)
  ) checker_i (.*);

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Run limit
  initial begin : watchdog
    #(TIMEOUT_UNITS);
    $display("Some tests failed");
    $finish;
  end

  // Receiver stalls: stretches of always-ready, light, heavy and periodic stalls
  initial begin : rx_pattern
    int span;
    int kind;
    int k;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      span = $urandom_range(1, 48);
      kind = $urandom_range(0, 3);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        if (rx_free || kind == 0) out_ready = 1'b1;
        else if (kind == 1) out_ready = ($urandom_range(0, 3) != 0);
        else if (kind == 2) out_ready = ($urandom_range(0, 1) != 0);
        else out_ready = ((k % 8) >= 5);
      end
    end
  end

  // One request; valid stays up until the DUT takes it
  task automatic push_tick(logic signed [CUR_W-1:0] sens, logic signed [CUR_W-1:0] target,
                           logic store, logic clr);
    @(negedge clk);
    in_valid             = 1'b1;
    in_sensed_current    = sens;
    in_reference_current = target;
    in_storing_data      = store;
    in_clear_integral    = clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  task automatic pause_tx(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Request inside a burst; at burst end a gap, sometimes a full drain
  task automatic paced_tick(logic signed [CUR_W-1:0] sens, logic signed [CUR_W-1:0] target,
                            logic store, logic clr);
    push_tick(sens, target, store, clr);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 19) == 0) drain();
      else pause_tx($urandom_range(1, 10));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Full register load; unused upper data bits carry noise
  task automatic load_regs(mode_t m, logic signed [DUTY_W-1:0] d,
                           logic signed [GAIN_W-1:0] kp, logic signed [GAIN_W-1:0] ki);
    logic [31:0] junk;
    junk = $urandom;
    drain();
    write_reg(CFG_MODE, {junk[13:0], m});
    write_reg(CFG_DUTY, {junk[23:16], d});
    write_reg(CFG_KP, kp);
    write_reg(CFG_KI, ki);
    n_settings++;
  endtask

  task automatic set_duty(logic signed [DUTY_W-1:0] d);
    logic [31:0] junk;
    junk = $urandom;
    drain();
    write_reg(CFG_DUTY, {junk[7:0], d});
    n_settings++;
  endtask

  function automatic logic signed [CUR_W-1:0] rand_current();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 600) - 300;
      1: v = ($urandom_range(0, 1) != 0) ? 4095 : -4096;
      default: v = $urandom;
    endcase
    return CUR_W'(v);
  endfunction

  function automatic logic signed [GAIN_W-1:0] rand_gain();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 2048) - 1024;
      2: v = $urandom_range(0, 64) - 32;
      default: begin
        case ($urandom_range(0, 2))
          0: v = 32767;
          1: v = -32768;
          default: v = 0;
        endcase
      end
    endcase
    return GAIN_W'(v);
  endfunction

  initial begin : stimulus
    int    p;
    int    k;
    int    pick;
    mode_t m;
    logic signed [DUTY_W-1:0] d;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_MODE;
    cfg_data             = '0;
    in_valid             = 1'b0;
    in_sensed_current    = '0;
    in_reference_current = '0;
    in_storing_data      = 1'b0;
    in_clear_integral    = 1'b0;
    rx_free              = 1'b0;
    burst_left           = 0;
    n_items              = 0;
    n_settings           = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Idle after reset, input extremes
    push_tick(CUR_MIN, CUR_MAX, 1'b1, 1'b1);
    push_tick(CUR_MAX, CUR_MIN, 1'b0, 1'b0);

    // Fixed duty: full scale both ways, out-of-range duty, small negative
    load_regs(MODE_FIXED, 8'sd100, '0, '0);
    push_tick(13'sd0, 13'sd0, 1'b0, 1'b0);
    set_duty(-8'sd100);
    push_tick(13'sd5, -13'sd5, 1'b1, 1'b0);
    set_duty(8'sd127);
    push_tick(13'sd0, 13'sd0, 1'b0, 1'b1);
    set_duty(8'sh80);
    push_tick(13'sd0, 13'sd0, 1'b0, 1'b0);
    set_duty(-8'sd1);
    push_tick(13'sd0, 13'sd0, 1'b0, 1'b0);

    // Tune: a tick without storing, then the square wave with a clear in between
    load_regs(MODE_TUNE, '0, 16'sh0100, 16'sh0010);
    push_tick(13'sd0, 13'sd123, 1'b0, 1'b0);
    push_tick(13'sd0, CUR_MIN, 1'b1, 1'b0);
    push_tick(13'sd100, 13'sd0, 1'b1, 1'b0);
    push_tick(CUR_MIN, 13'sd0, 1'b1, 1'b1);
    push_tick(CUR_MAX, 13'sd0, 1'b0, 1'b0);

    // Track with extreme gains and errors
    load_regs(MODE_TRACK, '0, 16'sh7FFF, 16'sh8000);
    push_tick(CUR_MIN, CUR_MAX, 1'b0, 1'b0);
    push_tick(CUR_MAX, CUR_MIN, 1'b0, 1'b0);
    push_tick(13'sd0, 13'sd0, 1'b1, 1'b1);
    load_regs(MODE_TRACK, '0, 16'sh8000, 16'sh7FFF);
    push_tick(CUR_MIN, CUR_MAX, 1'b0, 1'b0);
    push_tick(CUR_MAX, CUR_MIN, 1'b0, 1'b0);

    // Track with small gains, effort stays inside the clamp
    load_regs(MODE_TRACK, '0, 16'sd256, 16'sd1);
    push_tick(13'sd0, 13'sd50, 1'b0, 1'b0);
    push_tick(13'sd0, -13'sd37, 1'b0, 1'b0);
    push_tick(13'sd10, 13'sd10, 1'b0, 1'b1);

    // Random phases, each with a fresh setting or a single register write
    for (p = 0; p < RAND_PHASES; p++) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_reg(cfg_idx_t'($urandom_range(0, 3)), CFG_DATA_W'($urandom));
        n_settings++;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) m = MODE_IDLE;
        else if (pick < 3) m = MODE_FIXED;
        else if (pick < 6) m = MODE_TUNE;
        else m = MODE_TRACK;
        if ($urandom_range(0, 3) == 0)
          d = ($urandom_range(0, 1) != 0) ? 8'sd100 : -8'sd100;
        else
          d = DUTY_W'($urandom);
        load_regs(m, d, rand_gain(), rand_gain());
      end
      for (k = 0; k < PHASE_TICKS; k++)
        paced_tick(rand_current(), rand_current(), ($urandom_range(0, 6) != 0),
                   ($urandom_range(0, 24) == 0));
    end

    // Full-rate runs with full-scale error in each direction
    rx_free = 1'b1;
    load_regs(MODE_TRACK, '0, 16'sd3, 16'sd1);
    for (k = 0; k < SAT_TICKS; k++)
      push_tick(CUR_MIN, CUR_MAX, 1'b0, 1'b0);
    for (k = 0; k < 16; k++)
      push_tick(rand_current(), rand_current(), 1'b0, 1'b0);
    load_regs(MODE_TRACK, '0, -16'sd3, 16'sd1);
    for (k = 0; k < SAT_TICKS; k++)
      push_tick(CUR_MAX, CUR_MIN, 1'b0, 1'b0);
    for (k = 0; k < 16; k++)
      push_tick(rand_current(), rand_current(), 1'b0, 1'b0);
    rx_free = 1'b0;

    drain();
    repeat (20) @(negedge clk);

    $display("Covered %0d requests over %0d register settings, all four modes,",
             n_items, n_settings);
    $display("the tune square wave and back-to-back full-scale error; %0d results checked.",
             results_checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
